/* src/bge_pkg.sv */
// Shared types, constants and helpers for the button gesture and cursor engine.
package bge_pkg;

  // Record codes
  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_LONG  = 3'd2,
    EV_CLICK = 3'd3,
    EV_SAFE  = 3'd4
  } ev_type_e;

  typedef enum logic [1:0] {
    SRC_A   = 2'd0,
    SRC_B   = 2'd1,
    SRC_PWR = 2'd2
  } ev_src_e;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_MOVE  = 1'b1
  } rec_kind_e;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_CLICK_GAP  = 2'd1,
    REG_STREAK_GAP = 2'd2,
    REG_SPEED      = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] LongPressRst = 16'd600;
  localparam logic [15:0] ClickGapRst  = 16'd300;
  localparam logic [15:0] StreakGapRst = 16'd300;
  localparam logic [2:0]  SpeedRst     = 3'd1;
  localparam logic [2:0]  SpeedMin     = 3'd1;
  localparam logic [2:0]  SpeedMax     = 3'd5;

  // Motion constants
  localparam logic [2:0] StreakMax    = 3'd7;
  localparam int unsigned HoldBase    = 85;
  localparam int unsigned HoldMin     = 22;
  localparam int unsigned AccelDiv    = 22;
  // Hold time from which the repeat interval sits at its floor
  localparam int unsigned HoldFastMs  = (HoldBase - HoldMin) * AccelDiv;
  localparam int unsigned HoldFastW   = $clog2(HoldFastMs);
  // Reciprocal of the accel divisor, exact for every hold below HoldFastMs
  localparam int unsigned RecipShift  = 16;
  localparam int unsigned AccelRecip  = ((1 << RecipShift) + AccelDiv - 1) / AccelDiv;
  localparam int unsigned StepCapBase = 10;

  // Record slots, in the order records leave the block
  localparam int unsigned NumSlots = 15;
  typedef logic [3:0] slot_t;
  localparam slot_t SlotADown  = 4'd0;
  localparam slot_t SlotALong  = 4'd1;
  localparam slot_t SlotAUp    = 4'd2;
  localparam slot_t SlotBDown  = 4'd3;
  localparam slot_t SlotBLong  = 4'd4;
  localparam slot_t SlotBUp    = 4'd5;
  localparam slot_t SlotBMove  = 4'd6;
  localparam slot_t SlotPDown  = 4'd7;
  localparam slot_t SlotPLong  = 4'd8;
  localparam slot_t SlotPUp    = 4'd9;
  localparam slot_t SlotPMove  = 4'd10;
  localparam slot_t SlotSafe   = 4'd11;
  localparam slot_t SlotBHold  = 4'd12;
  localparam slot_t SlotPHold  = 4'd13;
  localparam slot_t SlotClick  = 4'd14;

  typedef struct packed {
    logic [15:0] long_press;
    logic [15:0] click_gap;
    logic [15:0] streak_gap;
    logic [2:0]  speed;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        held;
    logic [2:0]        long_sent;
    logic [2:0][31:0]  press_start;
    logic [31:0]       a_release;
    logic              a_click_pend;
    logic              combo;
    logic [3:0][2:0]   streak;
    logic [3:0][31:0]  last_step;
  } state_t;

  // All records of one item: a slot mask plus the variable step sizes and the stamp
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [4:0]          step_b;
    logic [4:0]          step_p;
    logic [4:0]          hold_b;
    logic [4:0]          hold_p;
    logic [31:0]         stamp;
  } rec_set_t;

  // min(speed*(1+2*streak), 10+2*speed)
  function automatic logic [4:0] step_size(input logic [2:0] streak, input logic [2:0] speed);
    logic [6:0] scaled;
    logic [4:0] cap;
    scaled = 7'({streak, 1'b1}) * 7'(speed);
    cap    = 5'(StepCapBase) + 5'({speed, 1'b0});
    step_size = (scaled > 7'(cap)) ? cap : scaled[4:0];
  endfunction

endpackage

/* src/button_gesture_cursor_engine.sv */
// Top level of the button gesture and cursor engine: item register, state, record buffer.
//
// Each item is one tick: a millisecond time and the levels of buttons A, B and power.
// The tick enters an input register, and the whole tick (edges, long presses, click
// timing, shortcut latch, streak and repeat stepping) is evaluated combinationally as
// the item moves into the record buffer, which also commits the new state. The
// buffer holds up to ten records of that tick and drains one record per cycle while
// out_stall_i is low, in slot order, with last_of_run_o on the final one. A tick
// with no records leaves the buffer empty, so quiet ticks stream back to back. The
// next tick is evaluated in the cycle the last record of the previous tick leaves,
// so the output channel is the only limit on rate. From the input handshake, a tick
// passes the input register and then the record buffer before its first record
// appears. Configuration writes are always accepted (cfg_ready_o is tied high); the
// speed register clamps writes to 1..5.
module button_gesture_cursor_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tick input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  now_ms_i,
  input  logic                         a_pressed_i,
  input  logic                         b_pressed_i,
  input  logic                         pwr_pressed_i,
  // record output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         record_kind_o,
  output logic [2:0]                   event_type_o,
  output logic [1:0]                   event_source_o,
  output logic signed [5:0]            move_dx_o,
  output logic signed [5:0]            move_dy_o,
  output logic [31:0]                  stamp_ms_o,
  output logic                         last_of_run_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bge_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bge_pkg::CfgDataW-1:0] cfg_data_i
);
  import bge_pkg::*;

  cfg_t        cfg_q;
  state_t      st_q, st_d;
  rec_set_t    recs_d, buf_q;

  logic        item_vld_q;
  logic [31:0] item_now_q;
  logic        item_a_q, item_b_q, item_p_q;

  logic [NumSlots-1:0] rest_mask, sel_mask;
  slot_t               sel_slot;
  logic                out_acc, buf_free, load;
  logic [2:0]          speed_w;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    speed_w = cfg_data_i[2:0];
    if (speed_w < SpeedMin) begin
      speed_w = SpeedMin;
    end else if (speed_w > SpeedMax) begin
      speed_w = SpeedMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press <= LongPressRst;
      cfg_q.click_gap  <= ClickGapRst;
      cfg_q.streak_gap <= StreakGapRst;
      cfg_q.speed      <= SpeedRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_LONG_PRESS: cfg_q.long_press <= cfg_data_i;
        REG_CLICK_GAP:  cfg_q.click_gap  <= cfg_data_i;
        REG_STREAK_GAP: cfg_q.streak_gap <= cfg_data_i;
        REG_SPEED:      cfg_q.speed      <= speed_w;
        default:        ;
      endcase
    end
  end

  // Record buffer drain: lowest pending slot goes first
  always_comb begin
    sel_slot = '0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (buf_q.mask[s]) begin
        sel_slot = slot_t'(s);
      end
    end
  end

  assign rest_mask = buf_q.mask & (buf_q.mask - NumSlots'(1));
  assign sel_mask  = buf_q.mask & ~rest_mask;
  assign out_valid_o = |buf_q.mask;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Buffer is free once empty, or as its last record leaves
  assign buf_free   = !out_valid_o || (out_acc && (rest_mask == '0));
  assign load       = item_vld_q && buf_free;
  assign in_stall_o = item_vld_q && !buf_free;

  // Input register: advance whenever the held item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_now_q <= now_ms_i;
      item_a_q   <= a_pressed_i;
      item_b_q   <= b_pressed_i;
      item_p_q   <= pwr_pressed_i;
    end
  end

  bge_eval u_eval (
    .cfg_i         (cfg_q),
    .st_i          (st_q),
    .now_ms_i      (item_now_q),
    .a_pressed_i   (item_a_q),
    .b_pressed_i   (item_b_q),
    .pwr_pressed_i (item_p_q),
    .st_o          (st_d),
    .recs_o        (recs_d)
  );

  // Commit state as the item enters the buffer; drop each record as it leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      buf_q <= '0;
    end else if (load) begin
      st_q  <= st_d;
      buf_q <= recs_d;
    end else if (out_acc) begin
      buf_q.mask <= rest_mask;
    end
  end

  // Decode the selected slot into a record
  always_comb begin
    record_kind_o  = KIND_EVENT;
    event_type_o   = EV_DOWN;
    event_source_o = SRC_A;
    move_dx_o      = '0;
    move_dy_o      = '0;
    unique case (sel_slot)
      SlotADown: event_type_o = EV_DOWN;
      SlotALong: event_type_o = EV_LONG;
      SlotAUp:   event_type_o = EV_UP;
      SlotBDown: event_source_o = SRC_B;
      SlotBLong: begin
        event_type_o   = EV_LONG;
        event_source_o = SRC_B;
      end
      SlotBUp: begin
        event_type_o   = EV_UP;
        event_source_o = SRC_B;
      end
      SlotBMove: begin
        record_kind_o  = KIND_MOVE;
        event_source_o = SRC_B;
        move_dx_o      = 6'({1'b0, buf_q.step_b});
      end
      SlotPDown: event_source_o = SRC_PWR;
      SlotPLong: begin
        event_type_o   = EV_LONG;
        event_source_o = SRC_PWR;
      end
      SlotPUp: begin
        event_type_o   = EV_UP;
        event_source_o = SRC_PWR;
      end
      SlotPMove: begin
        record_kind_o  = KIND_MOVE;
        event_source_o = SRC_PWR;
        move_dy_o      = 6'({1'b0, buf_q.step_p});
      end
      SlotSafe:  event_type_o = EV_SAFE;
      SlotBHold: begin
        record_kind_o  = KIND_MOVE;
        event_source_o = SRC_B;
        move_dx_o      = -6'({1'b0, buf_q.hold_b});
      end
      SlotPHold: begin
        record_kind_o  = KIND_MOVE;
        event_source_o = SRC_PWR;
        move_dy_o      = -6'({1'b0, buf_q.hold_p});
      end
      SlotClick: event_type_o = EV_CLICK;
      default:   ;
    endcase
  end

  assign stamp_ms_o    = buf_q.stamp;
  assign last_of_run_o = (rest_mask == '0) && |sel_mask;

endmodule

/* src/bge_eval.sv */
// One-tick evaluation: next state and the record set for a sampled item.
module bge_eval (
  input  bge_pkg::cfg_t     cfg_i,
  input  bge_pkg::state_t   st_i,
  input  logic [31:0]       now_ms_i,
  input  logic              a_pressed_i,
  input  logic              b_pressed_i,
  input  logic              pwr_pressed_i,
  output bge_pkg::state_t   st_o,
  output bge_pkg::rec_set_t recs_o
);
  import bge_pkg::*;

  logic [2:0]       pressed;
  logic [2:0]       down, lng, up, lsent_e;
  logic [2:0][31:0] start_e, hold_e;

  logic [3:0][31:0] gap;
  logic [3:0][2:0]  streak_adv;
  logic [3:0][4:0]  step_sz;

  logic [1:0]       up_move, hold_en, hold_fire;
  logic [1:0][6:0]  interval;

  logic             a_pend_e, click, safe;
  logic [31:0]      a_rel_e;

  assign pressed = {pwr_pressed_i, b_pressed_i, a_pressed_i};

  // Per-button edge and long-press detection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      down[i]    = pressed[i] & ~st_i.held[i];
      lsent_e[i] = down[i] ? 1'b0 : st_i.long_sent[i];
      start_e[i] = down[i] ? now_ms_i : st_i.press_start[i];
      hold_e[i]  = now_ms_i - start_e[i];
      lng[i]     = pressed[i] & ~lsent_e[i] & (hold_e[i] >= {16'd0, cfg_i.long_press});
      up[i]      = ~pressed[i] & st_i.held[i];
    end
  end

  // Streak candidates for each direction: B right, B left, power down, power up
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      gap[d] = now_ms_i - st_i.last_step[d];
      if (gap[d] <= {16'd0, cfg_i.streak_gap}) begin
        streak_adv[d] = (st_i.streak[d] < StreakMax) ? st_i.streak[d] + 3'd1 : st_i.streak[d];
      end else begin
        streak_adv[d] = '0;
      end
      step_sz[d] = step_size(streak_adv[d], cfg_i.speed);
    end
  end

  // Short-release steps and held repeat for B (j=0) and power (j=1)
  always_comb begin
    logic [HoldFastW-1:0]            h;
    logic [HoldFastW+RecipShift-1:0] prod;
    logic [6:0]                      accel;
    for (int j = 0; j < 2; j++) begin
      h    = hold_e[j+1][HoldFastW-1:0];
      prod = (HoldFastW+RecipShift)'(h) * (HoldFastW+RecipShift)'(AccelRecip);
      accel = 7'(prod >> RecipShift);
      if (hold_e[j+1] < 32'(HoldFastMs)) begin
        interval[j] = 7'(HoldBase) - accel;
      end else begin
        interval[j] = 7'(HoldMin);
      end
      up_move[j]   = up[j+1] & ~st_i.long_sent[j+1];
      hold_en[j]   = pressed[j+1] & (lsent_e[j+1] | lng[j+1]);
      hold_fire[j] = hold_en[j] & (gap[2*j+1] >= {25'd0, interval[j]});
    end
  end

  // Delayed click and two-button shortcut
  always_comb begin
    a_pend_e = st_i.a_click_pend | (up[0] & ~st_i.long_sent[0]);
    a_rel_e  = up[0] ? now_ms_i : st_i.a_release;
    click    = a_pend_e & ((now_ms_i - a_rel_e) >= {16'd0, cfg_i.click_gap});
    safe     = a_pressed_i & b_pressed_i & ~st_i.combo;
  end

  // Next state
  always_comb begin
    st_o              = st_i;
    st_o.held         = pressed;
    st_o.long_sent    = lsent_e | lng;
    st_o.press_start  = start_e;
    st_o.a_release    = a_rel_e;
    st_o.a_click_pend = a_pend_e & ~click;
    st_o.combo        = a_pressed_i & b_pressed_i;
    for (int j = 0; j < 2; j++) begin
      // forward direction
      if (up_move[j]) begin
        st_o.streak[2*j]    = streak_adv[2*j];
        st_o.last_step[2*j] = now_ms_i;
      end else if (up[j+1] | hold_en[j]) begin
        st_o.streak[2*j] = '0;
      end
      // reverse direction
      if (up[j+1]) begin
        st_o.streak[2*j+1] = '0;
      end else if (hold_fire[j]) begin
        st_o.streak[2*j+1]    = streak_adv[2*j+1];
        st_o.last_step[2*j+1] = now_ms_i;
      end
    end
  end

  // Record set
  always_comb begin
    recs_o            = '0;
    recs_o.mask[SlotADown] = down[0];
    recs_o.mask[SlotALong] = lng[0];
    recs_o.mask[SlotAUp]   = up[0];
    recs_o.mask[SlotBDown] = down[1];
    recs_o.mask[SlotBLong] = lng[1];
    recs_o.mask[SlotBUp]   = up[1];
    recs_o.mask[SlotBMove] = up_move[0];
    recs_o.mask[SlotPDown] = down[2];
    recs_o.mask[SlotPLong] = lng[2];
    recs_o.mask[SlotPUp]   = up[2];
    recs_o.mask[SlotPMove] = up_move[1];
    recs_o.mask[SlotSafe]  = safe;
    recs_o.mask[SlotBHold] = hold_fire[0];
    recs_o.mask[SlotPHold] = hold_fire[1];
    recs_o.mask[SlotClick] = click;
    recs_o.step_b = step_sz[0];
    recs_o.hold_b = step_sz[1];
    recs_o.step_p = step_sz[2];
    recs_o.hold_p = step_sz[3];
    recs_o.stamp  = now_ms_i;
  end

endmodule

/* sim/tb_button_gesture_cursor_engine.sv */
// Self-checking testbench for the button gesture and cursor engine, with its own record predictor.
`timescale 1ns / 1ps

module tb_button_gesture_cursor_engine;
  import bge_pkg::*;

  // Quiet cycles allowed before the run is declared hung. The slowest correct
  // stretch without any handshake is the settle pause plus a short random stall.
  localparam int WatchdogLimit = 2000;
  // Cycles to wait after the last expected record before touching registers:
  // a tick without records can still be in the input register.
  localparam int SettleCycles  = 8;
  localparam int NumPhases     = 8;
  localparam int TicksPerPhase = 55;
  localparam int ScriptRows    = 25;
  localparam int MaxPerTick    = 10;
  localparam int PrintCap      = 100;

  // Cursor directions of the streak and step tracking
  localparam int DirRight = 0;
  localparam int DirLeft  = 1;
  localparam int DirDown  = 2;
  localparam int DirUp    = 3;

  typedef struct packed {
    rec_kind_e         kind;
    ev_type_e          etype;
    ev_src_e           src;
    logic signed [5:0] dx;
    logic signed [5:0] dy;
    logic [31:0]       stamp;
    logic              last;
  } gesture_rec_t;

  // One row of the directed script. When typed is set, the record count and the
  // first record's code are given here and cross-checked against the forecast.
  typedef struct packed {
    logic [31:0] now;
    logic        a;
    logic        b;
    logic        p;
    logic        typed;
    logic [3:0]  count;
    ev_type_e    etype;
    ev_src_e     src;
  } script_row_t;

  // Drive every input to a known value from time zero.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           now_ms_i      = '0;
  logic                  a_pressed_i   = 1'b0;
  logic                  b_pressed_i   = 1'b0;
  logic                  pwr_pressed_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  record_kind_o;
  logic [2:0]            event_type_o;
  logic [1:0]            event_source_o;
  logic signed [5:0]     move_dx_o;
  logic signed [5:0]     move_dy_o;
  logic [31:0]           stamp_ms_o;
  logic                  last_of_run_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = REG_LONG_PRESS;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;

  // Predictor copy of the configuration
  logic [15:0] long_press = LongPressRst;
  logic [15:0] click_gap  = ClickGapRst;
  logic [15:0] streak_gap = StreakGapRst;
  logic [2:0]  speed      = SpeedRst;

  // Predictor copy of the gesture state, all clear at reset
  bit          held [3];
  bit          long_sent [3];
  logic [31:0] press_start [3];
  logic [31:0] a_release    = '0;
  bit          click_pend   = 1'b0;
  bit          combo        = 1'b0;
  logic [2:0]  streak [4];
  logic [31:0] last_step [4];

  gesture_rec_t tick_records [$];  // records of the tick just forecast
  gesture_rec_t due_records [$];   // records still owed by the block
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  bit           calm           = 1'b0;  // no idling on either side while set

  button_gesture_cursor_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .a_pressed_i    (a_pressed_i),
    .b_pressed_i    (b_pressed_i),
    .pwr_pressed_i  (pwr_pressed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .event_type_o   (event_type_o),
    .event_source_o (event_source_o),
    .move_dx_o      (move_dx_o),
    .move_dy_o      (move_dy_o),
    .stamp_ms_o     (stamp_ms_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 3; i++) begin
      held[i] = 1'b0;
      long_sent[i] = 1'b0;
      press_start[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      streak[i] = '0;
      last_step[i] = '0;
    end
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PrintCap)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Queue one record of the current tick; drop anything past the tick's limit.
  function automatic void emit(rec_kind_e k, ev_type_e t, ev_src_e s, int dx, int dy);
    gesture_rec_t r;
    if (tick_records.size() >= MaxPerTick) return;
    r.kind  = k;
    r.etype = t;
    r.src   = s;
    r.dx    = 6'(dx);
    r.dy    = 6'(dy);
    r.stamp = '0;
    r.last  = 1'b0;
    tick_records.push_back(r);
  endfunction

  // Advance the streak of one direction and return the resulting step size.
  function automatic int next_stride(int dir, logic [31:0] now);
    logic [31:0] gap;
    int          scaled;
    int          cap;
    gap = now - last_step[dir];
    if (gap <= {16'd0, streak_gap}) begin
      if (streak[dir] < StreakMax) streak[dir] = streak[dir] + 3'd1;
    end else begin
      streak[dir] = '0;
    end
    last_step[dir] = now;
    scaled = (1 + 2 * int'(streak[dir])) * int'(speed);
    cap    = int'(StepCapBase) + 2 * int'(speed);
    return (scaled > cap) ? cap : scaled;
  endfunction

  // Down, long and up events of one button, plus the step of B or power on a short release.
  function automatic void button_edges(ev_src_e s, bit pressed, logic [31:0] now);
    int src;
    int fwd;
    int st;
    src = int'(s);
    fwd = (s == SRC_B) ? DirRight : DirDown;
    if (pressed && !held[src]) begin
      held[src] = 1'b1;
      long_sent[src] = 1'b0;
      press_start[src] = now;
      emit(KIND_EVENT, EV_DOWN, s, 0, 0);
    end
    if (pressed && !long_sent[src] && (now - press_start[src]) >= {16'd0, long_press}) begin
      long_sent[src] = 1'b1;
      emit(KIND_EVENT, EV_LONG, s, 0, 0);
    end
    if (!pressed && held[src]) begin
      held[src] = 1'b0;
      emit(KIND_EVENT, EV_UP, s, 0, 0);
      if (s == SRC_A) begin
        // A long release never arms the click, but leaves an armed one alone
        a_release = now;
        if (!long_sent[src]) click_pend = 1'b1;
      end else if (!long_sent[src]) begin
        st = next_stride(fwd, now);
        streak[fwd + 1] = '0;
        if (s == SRC_B) emit(KIND_MOVE, EV_DOWN, s, st, 0);
        else emit(KIND_MOVE, EV_DOWN, s, 0, st);
      end else begin
        // Long release: clear both streaks of this button, no step
        streak[fwd] = '0;
        streak[fwd + 1] = '0;
      end
    end
  endfunction

  // Repeat steps backward while a button is held past its long press.
  function automatic void hold_repeat(ev_src_e s, logic [31:0] now);
    int          src;
    int          back;
    int          st;
    logic [31:0] accel;
    logic [31:0] interval;
    src  = int'(s);
    back = (s == SRC_B) ? DirLeft : DirUp;
    if (!(held[src] && long_sent[src])) return;
    accel    = (now - press_start[src]) / AccelDiv;
    interval = (HoldBase > accel + HoldMin) ? (HoldBase - accel) : HoldMin;
    streak[back - 1] = '0;
    if ((now - last_step[back]) >= interval) begin
      st = next_stride(back, now);
      if (s == SRC_B) emit(KIND_MOVE, EV_DOWN, s, -st, 0);
      else emit(KIND_MOVE, EV_DOWN, s, 0, -st);
    end
  endfunction

  // Work out every record of one tick and append them to the owed records.
  function automatic void forecast_tick(logic [31:0] now, bit a, bit b, bit p);
    tick_records.delete();
    button_edges(SRC_A, a, now);
    button_edges(SRC_B, b, now);
    button_edges(SRC_PWR, p, now);
    if (a && b && !combo) begin
      combo = 1'b1;
      emit(KIND_EVENT, EV_SAFE, SRC_A, 0, 0);
    end else if (!a || !b) begin
      combo = 1'b0;
    end
    hold_repeat(SRC_B, now);
    hold_repeat(SRC_PWR, now);
    if (click_pend && (now - a_release) >= {16'd0, click_gap}) begin
      emit(KIND_EVENT, EV_CLICK, SRC_A, 0, 0);
      click_pend = 1'b0;
    end
    for (int i = 0; i < tick_records.size(); i++) begin
      tick_records[i].stamp = now;
      tick_records[i].last  = (i == tick_records.size() - 1);
      due_records.push_back(tick_records[i]);
    end
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [15:0] data);
    logic [2:0] v;
    case (idx)
      REG_LONG_PRESS: long_press = data;
      REG_CLICK_GAP:  click_gap = data;
      REG_STREAK_GAP: streak_gap = data;
      REG_SPEED: begin
        // Only the low three bits count; clamp into the legal speed range
        v = data[2:0];
        if (v < SpeedMin) v = SpeedMin;
        if (v > SpeedMax) v = SpeedMax;
        speed = v;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one tick, forecast its records, and hold it until it is taken.
  task automatic send_tick(logic [31:0] now, bit a, bit b, bit p);
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= now;
    a_pressed_i   <= a;
    b_pressed_i   <= b;
    pwr_pressed_i <= p;
    forecast_tick(now, a, b, p);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every owed record has left, then let an empty tick clear out.
  task automatic settle();
    while (due_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four registers back to back; keep valid high across the burst.
  task automatic program_regs(logic [15:0] lp, logic [15:0] cg, logic [15:0] sg,
                              logic [15:0] sp);
    logic [15:0] vals [4];
    cfg_idx_e    idx;
    vals[REG_LONG_PRESS] = lp;
    vals[REG_CLICK_GAP]  = cg;
    vals[REG_STREAK_GAP] = sg;
    vals[REG_SPEED]      = sp;
    idx = REG_LONG_PRESS;
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stall the record channel now and then, except during the calm phase.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 6);
  end

  // ---------------------------------------------------------------------------
  // Record checker: compare each accepted record with the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_records
    gesture_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_records.size() == 0) begin
        flag_mismatch("record with nothing owed, stamp", stamp_ms_o, '0);
      end else begin
        want = due_records.pop_front();
        if (record_kind_o !== want.kind)
          flag_mismatch("record_kind", record_kind_o, want.kind);
        if (event_type_o !== want.etype)
          flag_mismatch("event_type", event_type_o, want.etype);
        if (event_source_o !== want.src)
          flag_mismatch("event_source", event_source_o, want.src);
        if (move_dx_o !== want.dx)
          flag_mismatch("move_dx", move_dx_o, want.dx);
        if (move_dy_o !== want.dy)
          flag_mismatch("move_dy", move_dy_o, want.dy);
        if (stamp_ms_o !== want.stamp)
          flag_mismatch("stamp_ms", stamp_ms_o, want.stamp);
        if (last_of_run_o !== want.last)
          flag_mismatch("last_of_run", last_of_run_o, want.last);
      end
    end
  end

  // Watchdog: end the run if no channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Directed script under the reset configuration. It walks clicks, short and
  // long presses, the A+B shortcut, streak growth, hold repeats of both
  // buttons, a three-button hold, and a press that spans the time wrap.
  script_row_t script [ScriptRows] = '{
    '{32'd0,    1'b0, 1'b0, 1'b0, 1'b1, 4'd0, EV_DOWN,  SRC_A},   // idle after reset
    '{32'd10,   1'b1, 1'b0, 1'b0, 1'b1, 4'd1, EV_DOWN,  SRC_A},
    '{32'd50,   1'b0, 1'b0, 1'b0, 1'b1, 4'd1, EV_UP,    SRC_A},   // arms the click
    '{32'd349,  1'b0, 1'b0, 1'b0, 1'b1, 4'd0, EV_DOWN,  SRC_A},   // one short of the gap
    '{32'd350,  1'b0, 1'b0, 1'b0, 1'b1, 4'd1, EV_CLICK, SRC_A},
    '{32'd400,  1'b0, 1'b1, 1'b0, 1'b1, 4'd1, EV_DOWN,  SRC_B},
    '{32'd450,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // step right, no streak
    '{32'd500,  1'b0, 1'b1, 1'b0, 1'b1, 4'd1, EV_DOWN,  SRC_B},
    '{32'd520,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // streak grows
    '{32'd600,  1'b1, 1'b1, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // shortcut latches
    '{32'd1300, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // long presses, repeat
    '{32'd1400, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},
    '{32'd1500, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // long releases
    '{32'd1600, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1, EV_DOWN,  SRC_PWR},
    '{32'd1650, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},   // step down
    '{32'd2000, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, EV_DOWN,  SRC_A},
    '{32'd2600, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, EV_DOWN,  SRC_A},
    '{32'd2610, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0, EV_DOWN,  SRC_A},   // inside repeat interval
    '{32'd3000, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, EV_DOWN,  SRC_A},
    '{32'd3500, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN,  SRC_A},
    '{32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, EV_DOWN, SRC_B},
    '{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN, SRC_A},  // release across wrap
    '{32'h0000_0020, 1'b1, 1'b0, 1'b0, 1'b1, 4'd1, EV_DOWN, SRC_A},
    '{32'h0000_0030, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN, SRC_A},
    '{32'h0000_0100, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, EV_DOWN, SRC_A}   // press, click pending
  };

  initial begin : stimulus
    logic [31:0] clock_now;
    logic [31:0] dt;
    bit          a_lvl;
    bit          b_lvl;
    bit          p_lvl;
    int          pick;

    // Hold reset, then release it once for good.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script; typed rows also cross-check the forecast.
    foreach (script[i]) begin
      send_tick(script[i].now, script[i].a, script[i].b, script[i].p);
      if (script[i].typed) begin
        if (tick_records.size() != script[i].count)
          flag_mismatch("script record count", tick_records.size(), script[i].count);
        else if (script[i].count != 0 && (tick_records[0].etype != script[i].etype ||
                                          tick_records[0].src != script[i].src))
          flag_mismatch("script record code", {tick_records[0].etype, tick_records[0].src},
                        {script[i].etype, script[i].src});
      end
    end
    in_valid_i <= 1'b0;

    clock_now = 32'h0000_0100;
    a_lvl = 1'b1;
    b_lvl = 1'b0;
    p_lvl = 1'b0;

    // Random phases, each under its own register setting. The first two pin the
    // extremes and the third is fixed; the calm phase runs with no idling on either side.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: program_regs(16'd0, 16'd0, 16'd0, 16'h0000);          // speed clamps up
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // speed clamps down
        2: program_regs(16'd100, 16'd50, 16'd200, 16'h0003);
        default: program_regs(16'($urandom_range(700)), 16'($urandom_range(400)),
                              16'($urandom_range(400)), 16'($urandom()));
      endcase
      calm = (ph == 4);
      for (int k = 0; k < TicksPerPhase; k++) begin
        // Advance time mostly in small steps, sometimes past the hold, click
        // or streak thresholds, and rarely by a jump anywhere in the range.
        pick = $urandom_range(99);
        if (pick < 50)      dt = $urandom_range(40);
        else if (pick < 70) dt = $urandom_range(32'(long_press) + 100);
        else if (pick < 82) dt = $urandom_range(32'(streak_gap) + 50);
        else if (pick < 95) dt = $urandom_range(32'(click_gap) + 50);
        else                dt = $urandom();
        clock_now = clock_now + dt;
        // Flip each button now and then so presses of all lengths occur.
        if ($urandom_range(99) < 30) a_lvl = !a_lvl;
        if ($urandom_range(99) < 30) b_lvl = !b_lvl;
        if ($urandom_range(99) < 30) p_lvl = !p_lvl;
        send_tick(clock_now, a_lvl, b_lvl, p_lvl);
      end
      in_valid_i <= 1'b0;
    end

    // Drain what is owed, give the block time to show any stray record, report.
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/bge_pkg.sv
src/bge_eval.sv
src/button_gesture_cursor_engine.sv
sim/tb_button_gesture_cursor_engine.sv
